// File: hw/rtl/dhcp_option_tlv_finder_defines.svh
// Assertion macros for the DHCP option finder.
// Both expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef DHCP_OPTION_TLV_FINDER_DEFINES_SVH
`define DHCP_OPTION_TLV_FINDER_DEFINES_SVH

`ifndef SYNTH

`define DOTF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dotf assertion failed");

`define DOTF_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("dotf forbidden condition");

`else

`define DOTF_ASSERT(label, prop)
`define DOTF_ASSERT_NEVER(label, cond)

`endif

`endif

// File: hw/rtl/dotf_pkg.sv
package dotf_pkg;

  // Area size limit; offsets saturate at the smaller of this minus one and 511.
  localparam int MaxOptionBytes = 512;
  localparam int PosMaxInt      = ((MaxOptionBytes - 1) < 511) ? (MaxOptionBytes - 1) : 511;
  localparam logic [8:0] PosMax = PosMaxInt[8:0];

  localparam logic [7:0] CodePad        = 8'd0;
  localparam logic [7:0] CodeEnd        = 8'd255;
  localparam logic [7:0] TargetCodeRst  = 8'd53;

  // Register map (word index)
  localparam logic RegTargetCode = 1'b0;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_VAL  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_SCANNING = 2'd0,
    ST_END_SEEN = 2'd1,
    ST_OVERRUN  = 2'd2,
    ST_NO_END   = 2'd3
  } status_e;

  typedef struct packed {
    logic       value_valid;
    logic [7:0] value_byte;
    logic [7:0] value_index;
    logic       found;
    logic [8:0] found_offset;
    logic [7:0] option_length;
    logic [8:0] byte_offset;
    status_e    status;
  } result_t;

endpackage

// File: hw/rtl/dhcp_option_tlv_finder.sv
// DHCP option finder: walks a DHCP options area fed one byte per request on
// the s_axis side (tlast closes the area) and returns one result per byte on
// m_axis. The first option whose code equals target_code is reported with its
// code offset and length byte, and its value bytes come out flagged in tuser
// with their index. Pad (0) is a lone byte, end (255) stops the walk; a target
// of 255 reports the end byte's offset. Status flags an option cut off by the
// end of the area (2) or an area that closes without an end option (3).
// Throughput is one byte per cycle while m_axis takes its results; the walk state
// updates in the cycle a byte is taken and the result lands in a single output
// register, which refills in the same cycle it drains. target_code sits at
// byte address 0 of the APB port and should only be written while idle.
`include "dhcp_option_tlv_finder_defines.svh"

module dhcp_option_tlv_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] value_byte, [15:8] value_index,
                                      // [16] found, [25:17] found_offset,
                                      // [33:26] option_length,
                                      // [42:34] byte_offset, [44:43] status,
                                      // [47:45] zero
  output logic        m_axis_tuser    // [0] value_valid
);

  // ---------------------------------------------------------------- config
  logic [7:0] target_code_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == dotf_pkg::RegTargetCode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_code_q <= dotf_pkg::TargetCodeRst;
    end else if (cfg_wr) begin
      target_code_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == dotf_pkg::RegTargetCode) begin
      prdata = {24'd0, target_code_q};
    end
  end

  // ---------------------------------------------------------------- walk state
  dotf_pkg::phase_e phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       in_match_q, in_match_d;
  logic       found_q, found_d;
  logic [8:0] match_offset_q, match_offset_d;
  logic [7:0] match_length_q, match_length_d;
  logic [7:0] value_count_q, value_count_d;
  logic [8:0] position_q, position_d;

  logic             out_valid_q;
  dotf_pkg::result_t res_q, res_d;
  logic             in_acc;
  logic [7:0]       b;

  // output register refills in the cycle it drains
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  always_comb begin
    phase_d        = phase_q;
    bytes_left_d   = bytes_left_q;
    in_match_d     = in_match_q;
    found_d        = found_q;
    match_offset_d = match_offset_q;
    match_length_d = match_length_q;
    value_count_d  = value_count_q;
    res_d          = '0;

    unique case (phase_q)
      dotf_pkg::PH_CODE: begin
        // only the first occurrence of the target counts
        if (b == target_code_q && !found_q) begin
          found_d        = 1'b1;
          match_offset_d = position_q;
          match_length_d = '0;
          value_count_d  = '0;
          in_match_d     = (b != dotf_pkg::CodePad) && (b != dotf_pkg::CodeEnd);
        end
        if (b == dotf_pkg::CodeEnd) begin
          phase_d    = dotf_pkg::PH_DONE;
          in_match_d = 1'b0;
        end else if (b != dotf_pkg::CodePad) begin
          phase_d = dotf_pkg::PH_LEN;
        end
      end
      dotf_pkg::PH_LEN: begin
        bytes_left_d = b;
        if (in_match_q) begin
          match_length_d = b;
          value_count_d  = '0;
        end
        if (b == 8'd0) begin
          phase_d    = dotf_pkg::PH_CODE;
          in_match_d = 1'b0;
        end else begin
          phase_d = dotf_pkg::PH_VAL;
        end
      end
      dotf_pkg::PH_VAL: begin
        if (in_match_q) begin
          res_d.value_valid = 1'b1;
          res_d.value_byte  = b;
          res_d.value_index = value_count_q;
          value_count_d     = value_count_q + 8'd1;
        end
        bytes_left_d = bytes_left_q - 8'd1;
        if (bytes_left_d == 8'd0) begin
          phase_d    = dotf_pkg::PH_CODE;
          in_match_d = 1'b0;
        end
      end
      dotf_pkg::PH_DONE: begin
        // bytes after the end option are ignored
      end
      default: begin
      end
    endcase

    if (phase_d == dotf_pkg::PH_DONE) begin
      res_d.status = dotf_pkg::ST_END_SEEN;
    end else if (s_axis_tlast &&
                 (phase_d == dotf_pkg::PH_LEN || phase_d == dotf_pkg::PH_VAL)) begin
      res_d.status = dotf_pkg::ST_OVERRUN;
    end else if (s_axis_tlast) begin
      res_d.status = dotf_pkg::ST_NO_END;
    end else begin
      res_d.status = dotf_pkg::ST_SCANNING;
    end

    res_d.found         = found_d;
    res_d.found_offset  = found_d ? match_offset_d : 9'd0;
    res_d.option_length = found_d ? match_length_d : 8'd0;
    res_d.byte_offset   = position_q;

    position_d = (position_q < dotf_pkg::PosMax) ? position_q + 9'd1 : dotf_pkg::PosMax;

    // tlast closes the area: everything but the target returns to reset
    if (s_axis_tlast) begin
      phase_d        = dotf_pkg::PH_CODE;
      bytes_left_d   = '0;
      in_match_d     = 1'b0;
      found_d        = 1'b0;
      match_offset_d = '0;
      match_length_d = '0;
      value_count_d  = '0;
      position_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= dotf_pkg::PH_CODE;
      bytes_left_q   <= '0;
      in_match_q     <= 1'b0;
      found_q        <= 1'b0;
      match_offset_q <= '0;
      match_length_q <= '0;
      value_count_q  <= '0;
      position_q     <= '0;
    end else if (in_acc) begin
      phase_q        <= phase_d;
      bytes_left_q   <= bytes_left_d;
      in_match_q     <= in_match_d;
      found_q        <= found_d;
      match_offset_q <= match_offset_d;
      match_length_q <= match_length_d;
      value_count_q  <= value_count_d;
      position_q     <= position_d;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.value_valid;
  assign m_axis_tdata  = {3'd0, res_q.status, res_q.byte_offset, res_q.option_length,
                          res_q.found_offset, res_q.found, res_q.value_index,
                          res_q.value_byte};

  // ---------------------------------------------------------------- checks
  `DOTF_ASSERT(a_match_implies_found, in_match_q |-> found_q)
  `DOTF_ASSERT(a_left_only_in_value, (phase_q != dotf_pkg::PH_VAL) |-> (bytes_left_q == 8'd0))
  `DOTF_ASSERT(a_index_below_len, (in_match_q && phase_q == dotf_pkg::PH_VAL) |-> (value_count_q < match_length_q))
  `DOTF_ASSERT(a_last_restarts, (in_acc && s_axis_tlast) |=> (position_q == 9'd0 && !found_q))
  `DOTF_ASSERT_NEVER(a_value_without_found, m_axis_tvalid && res_q.value_valid && !res_q.found)

endmodule
